// File: rtl/r2fft_pkg.sv
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types, constants and the twiddle ROM for the radix-2 FFT block.
// ----------------------------------------------------------------------------
package r2fft_pkg;

    localparam int MaxPointsDef  = 64;
    localparam int SampleBitsDef = 16;
    localparam int StoreBitsDef  = 24;
    localparam int RomLog2       = 6;
    localparam int OutBits       = 24;
    localparam int InBits        = 16;
    localparam int IdxBits       = 6;
    localparam int TwBits        = 17;

    localparam logic CfgInverse = 1'b0;
    localparam logic CfgSize    = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_WR,
        ST_EMIT_RD,
        ST_EMIT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic       load_wr;
        logic       rd_a;
        logic       rd_b;
        logic       bfly_wr;
        logic       emit_rd;
        logic [5:0] addr_a;
        logic [5:0] addr_b;
        logic [5:0] tw_idx;
    } t_cmd;

    // quarter-wave cosine table, 1.0 held as 32768
    function automatic logic [16:0] quarter_cos(input logic [4:0] m);
        logic [16:0] v;
        case (m)
            5'd0:  v = 17'd32768;
            5'd1:  v = 17'd32610;
            5'd2:  v = 17'd32138;
            5'd3:  v = 17'd31357;
            5'd4:  v = 17'd30274;
            5'd5:  v = 17'd28899;
            5'd6:  v = 17'd27246;
            5'd7:  v = 17'd25330;
            5'd8:  v = 17'd23170;
            5'd9:  v = 17'd20788;
            5'd10: v = 17'd18205;
            5'd11: v = 17'd15447;
            5'd12: v = 17'd12540;
            5'd13: v = 17'd9512;
            5'd14: v = 17'd6393;
            5'd15: v = 17'd3212;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [TwBits-1:0] rom_cos(input logic [5:0] m);
        logic [4:0] mm;
        mm = m[4:0];
        if (mm <= 5'd16) return $signed(quarter_cos(mm));
        return -$signed(quarter_cos(5'(6'd32 - {1'b0, mm})));
    endfunction

    function automatic logic signed [TwBits-1:0] rom_sin(input logic [5:0] m);
        logic [4:0] mm;
        mm = m[4:0];
        if (mm <= 5'd16) return $signed(quarter_cos(5'(5'd16 - mm)));
        return $signed(quarter_cos(5'(mm - 5'd16)));
    endfunction

endpackage

// File: rtl/r2fft_stream_if.sv
// ----------------------------------------------------------------------------
// r2fft_stream_if
// Valid/ready channel carrying a generic payload.
// ----------------------------------------------------------------------------
interface r2fft_stream_if #(parameter int W = 32);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/radix2_fft_ifft_top.sv
// ----------------------------------------------------------------------------
// radix2_fft_ifft_top
// Radix-2 decimation-in-time FFT/IFFT, fixed point, one butterfly unit.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch (sink) takes one complex sample per transfer; samples land at
//    bit-reversed addresses of the point store.
//  - After N = 2^size_log2 samples the input stalls while log2(N) stages of
//    N/2 butterflies run, each two store reads and then one dual write.
//  - out_ch (source) then gives N points in index order, last_point on N-1.
//    Each point is a store read into the read register, then the transfer.
//  - Load, butterfly passes and emit of a frame run one after another, set
//    by the single shared butterfly and store read port.
//  - Receiver stall holds the current point; nothing is lost.
//  - Reset: forward mode, size 6, load count zero. Store contents undefined.
//  - Config writes (index 0 inverse_mode, 1 size_log2) discard a partial
//    frame; size above 6 acts as 6.
// ----------------------------------------------------------------------------
module radix2_fft_ifft_top
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MaxPointsDef,
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int STORE_BITS  = StoreBitsDef
)(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_idx,
    input  logic [2:0] i_cfg_data,
    r2fft_stream_if.sink   in_ch,
    r2fft_stream_if.source out_ch
);
    localparam logic [2:0] MaxLg = 3'($clog2(MAX_POINTS));

    logic       r_inv;
    logic [2:0] r_size;
    logic [2:0] lg;
    t_cmd       cmd;
    logic       emit_valid, last, in_fire, out_fire;
    logic [5:0] emit_idx;
    logic signed [OutBits-1:0] d_re, d_im;

    assign lg = (r_size > MaxLg) ? MaxLg : r_size;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_fire = out_ch.valid && out_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv  <= 1'b0;
            r_size <= 3'd6;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgInverse: r_inv  <= i_cfg_data[0];
                CfgSize:    r_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    r2fft_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_lg(lg), .i_cfg_we(i_cfg_we),
        .i_in_fire(in_fire), .i_out_fire(out_fire), .i_out_busy(1'b0),
        .o_in_ready(in_ch.ready), .o_emit_valid(emit_valid), .o_last(last),
        .o_emit_idx(emit_idx), .o_cmd(cmd)
    );

    r2fft_dp #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS),
               .STORE_BITS(STORE_BITS)) u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_inv(r_inv), .i_lg(lg),
        .i_re(in_ch.data[31:16]), .i_im(in_ch.data[15:0]),
        .o_re(d_re), .o_im(d_im)
    );

    // data: re[54:31] im[30:7] idx[6:1] last[0]
    assign out_ch.valid = emit_valid;
    assign out_ch.data  = {d_re, d_im, emit_idx, last};
endmodule

// File: rtl/r2fft_ctrl.sv
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Sequencer: load, butterfly passes on one shared unit, emit.
// ----------------------------------------------------------------------------
module r2fft_ctrl
    import r2fft_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [2:0] i_lg,
    input  logic       i_cfg_we,
    input  logic       i_in_fire,
    input  logic       i_out_fire,
    input  logic       i_out_busy,
    output logic       o_in_ready,
    output logic       o_emit_valid,
    output logic       o_last,
    output logic [5:0] o_emit_idx,
    output t_cmd       o_cmd
);
    t_state     r_state, n_state;
    logic [6:0] r_cnt, n_cnt;
    logic [2:0] r_stg, n_stg;
    logic [4:0] r_bf, n_bf;
    logic [6:0] npts;
    logic [5:0] half, jj, kk, a_addr, rev;
    logic       bf_done, stg_done;

    assign npts = 7'd1 << i_lg;
    assign half = 6'(7'd1 << (r_stg - 3'd1));
    assign jj   = {1'b0, r_bf & 5'(half - 6'd1)};
    assign kk   = ({1'b0, r_bf} - jj) << 1;
    assign a_addr = kk + jj;
    assign bf_done  = ({2'b0, r_bf} == 7'((npts >> 1) - 7'd1));
    assign stg_done = (r_stg == i_lg);

    always_comb begin
        rev = '0;
        for (int i = 0; i < 6; i++)
            if (i < int'(i_lg)) rev[int'(i_lg) - 1 - i] = r_cnt[i];
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_stg = r_stg;
        n_bf  = r_bf;
        unique case (r_state)
            ST_LOAD: begin
                if (i_cfg_we) n_cnt = '0;
                else if (i_in_fire) begin
                    if (r_cnt + 7'd1 >= npts) begin
                        n_cnt = '0;
                        n_bf  = '0;
                        n_stg = 3'd1;
                        n_state = (i_lg == 3'd0) ? ST_EMIT_RD : ST_RD_A;
                    end else n_cnt = r_cnt + 7'd1;
                end
            end
            ST_RD_A: n_state = ST_RD_B;
            ST_RD_B: n_state = ST_WR;
            ST_WR: begin
                n_state = ST_RD_A;
                if (bf_done) begin
                    n_bf = '0;
                    if (stg_done) n_state = ST_EMIT_RD;
                    else n_stg = r_stg + 3'd1;
                end else n_bf = r_bf + 5'd1;
            end
            ST_EMIT_RD: if (!i_out_busy) n_state = ST_EMIT;
            ST_EMIT: if (i_out_fire) begin
                if (r_cnt + 7'd1 >= npts) begin
                    n_cnt = '0;
                    n_state = ST_LOAD;
                end else begin
                    n_cnt = r_cnt + 7'd1;
                    n_state = ST_EMIT_RD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.tw_idx = 6'(jj << (3'd6 - r_stg));
        o_cmd.addr_a = a_addr;
        o_cmd.addr_b = a_addr + half;
        o_in_ready = 1'b0;
        o_emit_valid = 1'b0;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load_wr = i_in_fire;
                o_cmd.addr_a = rev;
            end
            ST_RD_A: o_cmd.rd_a = 1'b1;
            ST_RD_B: o_cmd.rd_b = 1'b1;
            ST_WR:   o_cmd.bfly_wr = 1'b1;
            ST_EMIT_RD: begin
                o_cmd.emit_rd = !i_out_busy;
                o_cmd.addr_a = r_cnt[5:0];
            end
            ST_EMIT: o_emit_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_emit_idx = r_cnt[5:0];
    assign o_last = (r_cnt + 7'd1 >= npts);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt <= '0;
            r_stg <= 3'd1;
            r_bf <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_stg <= n_stg;
            r_bf <= n_bf;
        end
    end
endmodule

// File: rtl/r2fft_dp.sv
// ----------------------------------------------------------------------------
// r2fft_dp
// Point store, butterfly unit, output scaling and output register.
// ----------------------------------------------------------------------------
module r2fft_dp
    import r2fft_pkg::*;
#(
    parameter int MAX_POINTS  = MaxPointsDef,
    parameter int SAMPLE_BITS = SampleBitsDef,
    parameter int STORE_BITS  = StoreBitsDef
)(
    input  logic                   i_clk,
    input  t_cmd                   i_cmd,
    input  logic                   i_inv,
    input  logic [2:0]             i_lg,
    input  logic signed [InBits-1:0] i_re,
    input  logic signed [InBits-1:0] i_im,
    output logic signed [OutBits-1:0] o_re,
    output logic signed [OutBits-1:0] o_im
);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SB = STORE_BITS;
    localparam int PB = SB + TwBits + 2;
    localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};
    localparam int OW = (SB + 1 > OutBits) ? SB + 1 : OutBits + 1;
    localparam logic signed [OW-1:0] OMAX = {{(OW-OutBits+1){1'b0}}, {(OutBits-1){1'b1}}};
    localparam logic signed [OW-1:0] OMIN = {{(OW-OutBits+1){1'b1}}, {(OutBits-1){1'b0}}};

    logic [2*SB-1:0] r_mem [MAX_POINTS];
    logic [2*SB-1:0] r_rd;
    logic signed [SB-1:0] r_ar, r_ai;
    logic signed [SB-1:0] in_re, in_im, ar, ai, br, bi, tr, ti;
    logic signed [SAMPLE_BITS-1:0] s_re, s_im;
    logic signed [TwBits-1:0] wr, wi;
    logic signed [PB-1:0] pr, pi;
    logic signed [SB:0] sr, si, dr, di;
    logic signed [SB:0] er, ei;

    function automatic logic signed [SB-1:0] sat_w(input logic signed [PB-1:0] x);
        if (x > PB'(SMAX)) return SMAX;
        if (x < PB'(SMIN)) return SMIN;
        return SB'(x);
    endfunction

    function automatic logic signed [SB-1:0] sat1(input logic signed [SB:0] x);
        if (x > (SB+1)'(SMAX)) return SMAX;
        if (x < (SB+1)'(SMIN)) return SMIN;
        return SB'(x);
    endfunction

    function automatic logic signed [OutBits-1:0] sat_o(input logic signed [SB:0] x);
        logic signed [OW-1:0] xx;
        xx = OW'(x);
        if (xx > OMAX) return {1'b0, {(OutBits-1){1'b1}}};
        if (xx < OMIN) return {1'b1, {(OutBits-1){1'b0}}};
        return OutBits'(xx);
    endfunction

    function automatic logic signed [SB-1:0] sat_in(input logic signed [SAMPLE_BITS-1:0] x);
        localparam int W = (SAMPLE_BITS > SB) ? SAMPLE_BITS : SB;
        logic signed [W-1:0] xx;
        xx = W'(x);
        if (xx > W'(SMAX)) return SMAX;
        if (xx < W'(SMIN)) return SMIN;
        return SB'(xx);
    endfunction

    assign s_re  = SAMPLE_BITS'(i_re);
    assign s_im  = SAMPLE_BITS'(i_im);
    assign in_re = sat_in(s_re);
    assign in_im = sat_in(s_im);

    assign br = r_rd[2*SB-1:SB];
    assign bi = r_rd[SB-1:0];
    assign wr = rom_cos(i_cmd.tw_idx);
    assign wi = i_inv ? rom_sin(i_cmd.tw_idx) : -rom_sin(i_cmd.tw_idx);
    assign pr = (PB'(br) * PB'(wr) - PB'(bi) * PB'(wi) + PB'(16384)) >>> 15;
    assign pi = (PB'(br) * PB'(wi) + PB'(bi) * PB'(wr) + PB'(16384)) >>> 15;
    assign tr = sat_w(pr);
    assign ti = sat_w(pi);
    assign ar = r_ar;
    assign ai = r_ai;
    assign sr = (SB+1)'(ar) + (SB+1)'(tr);
    assign si = (SB+1)'(ai) + (SB+1)'(ti);
    assign dr = (SB+1)'(ar) - (SB+1)'(tr);
    assign di = (SB+1)'(ai) - (SB+1)'(ti);

    // inverse scaling by rounding arithmetic shift
    always_comb begin
        er = (SB+1)'($signed(r_rd[2*SB-1:SB]));
        ei = (SB+1)'($signed(r_rd[SB-1:0]));
        if (i_inv && i_lg != 3'd0) begin
            er = (er + ((SB+1)'(1) <<< (i_lg - 3'd1))) >>> i_lg;
            ei = (ei + ((SB+1)'(1) <<< (i_lg - 3'd1))) >>> i_lg;
        end
    end

    // read register holds the point for the whole emit cycle
    assign o_re = sat_o(er);
    assign o_im = sat_o(ei);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr) r_mem[AW'(i_cmd.addr_a)] <= {in_re, in_im};
        if (i_cmd.bfly_wr) begin
            r_mem[AW'(i_cmd.addr_a)] <= {sat1(sr), sat1(si)};
            r_mem[AW'(i_cmd.addr_b)] <= {sat1(dr), sat1(di)};
        end
        if (i_cmd.rd_a || i_cmd.emit_rd) r_rd <= r_mem[AW'(i_cmd.addr_a)];
        if (i_cmd.rd_b) r_rd <= r_mem[AW'(i_cmd.addr_b)];
        if (i_cmd.rd_b) begin
            r_ar <= $signed(r_rd[2*SB-1:SB]);
            r_ai <= $signed(r_rd[SB-1:0]);
        end
    end
endmodule

// File: rtl/r2fft_checker.sv
// ----------------------------------------------------------------------------
// r2fft_checker
// Port-level checks on the FFT block.
// ----------------------------------------------------------------------------
module r2fft_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [54:0] out_data
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid)) else $error("input open during emit");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled point changed");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && out_data[0] |=> !out_valid)
        else $error("point after last");
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_data[0] |=> ##1
        out_valid && out_data[6:1] == $past(out_data[6:1], 2) + 6'd1)
        else $error("index skipped");
endmodule

bind radix2_fft_ifft_top r2fft_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);

// File: tb/radix2_fft_ifft_top_tb.sv
// ----------------------------------------------------------------------------
// radix2_fft_ifft_top_tb
// Self-checking bench for the radix-2 FFT/IFFT block. A driver streams
// complex samples from a queue; a scoreboard model rebuilds every frame in
// fixed point and checks each output point field by field. Phases switch
// mode and size while the block is idle and vary source gaps and sink stalls.
// ----------------------------------------------------------------------------
module radix2_fft_ifft_top_tb;
    import r2fft_pkg::*;

    localparam int InW  = 2 * InBits;
    localparam int OutW = 2 * OutBits + IdxBits + 1;
    // margin for the longest frame: 64-point load, butterfly passes and emit
    localparam int FrameLat = 800;

    typedef struct {
        logic signed [InBits-1:0] re;
        logic signed [InBits-1:0] im;
    } sample_t;

    typedef struct {
        logic signed [OutBits-1:0] re;
        logic signed [OutBits-1:0] im;
        logic [IdxBits-1:0]        idx;
        logic                      last;
    } point_t;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [0:0] i_cfg_idx;
    logic [2:0] i_cfg_data;

    r2fft_stream_if #(.W(InW))  in_ch ();
    r2fft_stream_if #(.W(OutW)) out_ch ();

    radix2_fft_ifft_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch),
        .out_ch     (out_ch)
    );

    // stimulus and scoreboard
    sample_t sample_queue[$];
    point_t  spectrum_queue[$];
    int      fail_count = 0;

    // traffic shaping, set per phase by the sequencer
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;
    bit long_hold_armed = 0;
    int sink_hold_left = 0;

    // model state: working store and config
    longint mdl_re[64];
    longint mdl_im[64];
    int     mdl_fill = 0;
    bit     mdl_inverse = 0;
    int     mdl_size = 6;

    int qcos[17] = '{32768, 32610, 32138, 31357, 30274, 28899, 27246, 25330, 23170,
                     20788, 18205, 15447, 12540, 9512, 6393, 3212, 0};

    always #5 i_clk = ~i_clk;

    function automatic longint sat_store(longint x);
        if (x > 64'sd8388607) return 64'sd8388607;
        if (x < -64'sd8388608) return -64'sd8388608;
        return x;
    endfunction

    function automatic longint round_shr(longint x, int k);
        if (k == 0) return x;
        return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function automatic longint tw_cos(int m);
        int mm;
        mm = m & 31;
        return (mm <= 16) ? longint'(qcos[mm]) : -longint'(qcos[32 - mm]);
    endfunction

    function automatic longint tw_sin(int m);
        int mm;
        mm = m & 31;
        return (mm <= 16) ? longint'(qcos[16 - mm]) : longint'(qcos[mm - 16]);
    endfunction

    // load one sample; on frame completion run all stages and queue the spectrum
    task automatic absorb_sample(sample_t s);
        int lg, n, addr, st, k, j, m, a, b;
        longint wr, wi, br, bi, tr, ti, ar, ai, re, im;
        point_t p;
        lg = (mdl_size > 6) ? 6 : mdl_size;
        n = 1 << lg;
        addr = 0;
        for (int i = 0; i < lg; i++) addr = (addr << 1) | ((mdl_fill >> i) & 1);
        mdl_re[addr] = sat_store(longint'(s.re));
        mdl_im[addr] = sat_store(longint'(s.im));
        mdl_fill++;
        if (mdl_fill < n) return;
        for (st = 1; st <= lg; st++) begin
            for (k = 0; k < n; k += (1 << st)) begin
                for (j = 0; j < (1 << (st - 1)); j++) begin
                    m = j << (6 - st);
                    a = k + j;
                    b = k + j + (1 << (st - 1));
                    wr = tw_cos(m);
                    wi = mdl_inverse ? tw_sin(m) : -tw_sin(m);
                    br = mdl_re[b];
                    bi = mdl_im[b];
                    tr = sat_store(round_shr(br * wr - bi * wi, 15));
                    ti = sat_store(round_shr(br * wi + bi * wr, 15));
                    ar = mdl_re[a];
                    ai = mdl_im[a];
                    mdl_re[a] = sat_store(ar + tr);
                    mdl_im[a] = sat_store(ai + ti);
                    mdl_re[b] = sat_store(ar - tr);
                    mdl_im[b] = sat_store(ai - ti);
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            re = mdl_re[i];
            im = mdl_im[i];
            if (mdl_inverse) begin
                re = round_shr(re, lg);
                im = round_shr(im, lg);
            end
            p.re   = OutBits'(sat_store(re));
            p.im   = OutBits'(sat_store(im));
            p.idx  = IdxBits'(i);
            p.last = (i == n - 1);
            spectrum_queue.push_back(p);
        end
        mdl_fill = 0;
    endtask

    // driver: offer the next sample after a random gap, hold it until transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready)
                absorb_sample('{re: in_ch.data[InW-1:InBits], im: in_ch.data[InBits-1:0]});
            if (!in_ch.valid || in_ch.ready) begin
                if (sample_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    sample_t s;
                    s = sample_queue.pop_front();
                    in_ch.data  <= {s.re, s.im};
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random sink stalls, one long hold when armed, compare each point
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                point_t got, exp_pt;
                {got.re, got.im, got.idx, got.last} = out_ch.data;
                if (spectrum_queue.size() == 0) begin
                    $display("%0t: unexpected point re=%0d im=%0d idx=%0d last=%0b",
                             $time, got.re, got.im, got.idx, got.last);
                    fail_count++;
                end else begin
                    exp_pt = spectrum_queue.pop_front();
                    if (got.re !== exp_pt.re) begin
                        $display("%0t: result_re expected %0d actual %0d (idx %0d)",
                                 $time, exp_pt.re, got.re, exp_pt.idx);
                        fail_count++;
                    end
                    if (got.im !== exp_pt.im) begin
                        $display("%0t: result_im expected %0d actual %0d (idx %0d)",
                                 $time, exp_pt.im, got.im, exp_pt.idx);
                        fail_count++;
                    end
                    if (got.idx !== exp_pt.idx) begin
                        $display("%0t: point_index expected %0d actual %0d",
                                 $time, exp_pt.idx, got.idx);
                        fail_count++;
                    end
                    if (got.last !== exp_pt.last) begin
                        $display("%0t: last_point expected %0b actual %0b (idx %0d)",
                                 $time, exp_pt.last, got.last, exp_pt.idx);
                        fail_count++;
                    end
                end
            end
            if (sink_hold_left > 0) begin
                sink_hold_left <= sink_hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (long_hold_armed && out_ch.valid) begin
                // sink goes quiet long enough for the block to back up its input
                long_hold_armed <= 1'b0;
                sink_hold_left <= 1500;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // wait until all samples are taken and every point has been checked
    task automatic wait_drained(int extra);
        do @(negedge i_clk);
        while (sample_queue.size() != 0 || in_ch.valid || spectrum_queue.size() != 0
               || sink_hold_left != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [2:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CfgInverse) mdl_inverse = val[0];
        else                   mdl_size = val;
        mdl_fill = 0;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(bit inv, int size);
        wait_drained(20);
        write_reg(CfgInverse, inv);
        write_reg(CfgSize, 3'(size));
    endtask

    task automatic push_sample(int re, int im);
        sample_queue.push_back('{re: re[15:0], im: im[15:0]});
    endtask

    function automatic int rand_value(int flavor);
        case (flavor)
            0: return $urandom_range(65535) - 32768;
            1: return $urandom_range(511) - 256;
            default: return ($urandom_range(1) != 0) ? 32767 : -32768;
        endcase
    endfunction

    task automatic push_frames(int size, int frames);
        int n, flavor;
        n = 1 << ((size > 6) ? 6 : size);
        for (int f = 0; f < frames; f++) begin
            flavor = ($urandom_range(9) < 6) ? 0 : $urandom_range(1, 2);
            for (int i = 0; i < n; i++) push_sample(rand_value(flavor), rand_value(flavor));
        end
    endtask

    task automatic set_traffic(int mode);
        case (mode % 4)
            0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin src_idle_pct = 62; sink_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  sink_stall_pct = 62; end
            default: begin src_idle_pct = 35; sink_stall_pct = 35; end
        endcase
    endtask

    initial begin
        int queued, size, phase_no;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single-point frames: each sample comes straight back, full-scale corners
        configure(1'b0, 0);
        push_sample(32767, -32768);
        push_sample(-32768, 32767);
        push_sample(0, 0);
        push_sample(-1, 1);
        // two-point inverse: rounding of the divide by N
        configure(1'b1, 1);
        push_sample(32767, 32767);
        push_sample(-32768, -32768);
        push_sample(3, -3);
        push_sample(0, 1);
        // partial frame thrown away by a register write
        configure(1'b0, 2);
        push_sample(1000, -1000);
        push_sample(32767, 32767);
        push_sample(-32768, 5);
        wait_drained(20);
        write_reg(CfgInverse, 1'b0);
        push_sample(32767, 0);
        push_sample(0, 32767);
        push_sample(-32768, 0);
        push_sample(0, -32768);

        // size above the maximum acts as 64 points, then the largest inverse
        set_traffic(1);
        configure(1'b0, 7);
        push_frames(7, 1);
        set_traffic(3);
        configure(1'b1, 6);
        push_frames(6, 1);

        // long sink hold with the source pushing flat out
        set_traffic(0);
        configure(1'b0, 2);
        long_hold_armed = 1'b1;
        push_frames(2, 12);

        // about 190 samples so far; random phases fill up the rest
        queued = 0;
        phase_no = 0;
        while (queued < 210) begin
            set_traffic(phase_no);
            size = ($urandom_range(9) == 0) ? $urandom_range(4, 5) : $urandom_range(0, 3);
            configure($urandom_range(1), size);
            push_frames(size, $urandom_range(1, 4));
            queued += sample_queue.size();
            phase_no++;
        end

        wait_drained(FrameLat);
        if (fail_count == 0)
            $display("[radix2_fft_ifft_top] OK");
        else
            $display("[radix2_fft_ifft_top] ERROR");
        $finish;
    end

    initial begin
        #5000000;
        $display("[radix2_fft_ifft_top] ERROR");
        $finish;
    end

endmodule
